// File: rtl/pee_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pee_pkg
// Shared types, constants and helpers for the prefix expression evaluator.
// ============================================================================
package pee_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int CHAR_W          = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_DIVZERO   = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_SKIP = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } item_t;

    // first error of an expression wins
    function automatic err_t note_error(input err_t cur, input err_t code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

// File: rtl/pee_front.sv
`timescale 1ns / 1ps
// ============================================================================
// pee_front
// Accepts characters, classifies them and buffers them in a two-entry queue.
// ============================================================================
module pee_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pee_pkg::CHAR_W-1:0]  char_code,
    input  logic                        last_char,
    input  logic                        char_valid,
    output logic                        char_ready,
    output pee_pkg::item_t              item,
    output logic                        item_valid,
    input  logic                        item_ready
);
    import pee_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t            q_mem [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   cnt_reg;
    logic [QCW-1:0]   cnt_next;
    item_t            dec;
    logic             push;
    logic             pop;

    always_comb
    begin
        dec.char_code = char_code;
        dec.last      = last_char;
        unique case (char_code)
            CH_SPACE: dec.op = OP_SKIP;
            CH_PLUS:  dec.op = OP_ADD;
            CH_MINUS: dec.op = OP_SUB;
            CH_STAR:  dec.op = OP_MUL;
            CH_SLASH: dec.op = OP_DIV;
            default:  dec.op = OP_PUSH;
        endcase
    end

    assign char_ready = (cnt_reg != QCW'(QUEUE_DEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = q_mem[rd_ptr_reg];
    assign push       = char_valid && char_ready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/pee_back.sv
`timescale 1ns / 1ps
// ============================================================================
// pee_back
// Executes classified items on the value stack; iterative restoring divider.
// ============================================================================
module pee_back #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pee_pkg::item_t                     item,
    input  logic                               item_valid,
    output logic                               item_ready,
    output logic signed [pee_pkg::DATA_W-1:0]  result_value,
    output logic [1:0]                         error_code,
    output logic                               result_valid,
    input  logic                               result_ready
);
    import pee_pkg::*;

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int DCW = $clog2(DATA_W);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_OPRD   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_DFIX   = 8'b0001_0000,
        S_WR     = 8'b0010_0000,
        S_ENDRD  = 8'b0100_0000,
        S_ENDOUT = 8'b1000_0000
    } state_t;

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    state_t              state_reg,  state_next;
    logic [CW-1:0]       count_reg,  count_next;
    err_t                err_reg,    err_next;
    op_t                 op_reg,     op_next;
    logic                last_reg,   last_next;
    logic [DATA_W-1:0]   left_reg,   left_next;
    logic [DATA_W-1:0]   right_reg,  right_next;
    logic [DATA_W-1:0]   res_reg,    res_next;
    logic [DATA_W-1:0]   rem_reg,    rem_next;
    logic [DATA_W-1:0]   quo_reg,    quo_next;
    logic [DATA_W-1:0]   dsor_reg,   dsor_next;
    logic [DCW-1:0]      dcnt_reg,   dcnt_next;
    logic                neg_reg,    neg_next;
    logic                ovld_reg,   ovld_next;
    logic [DATA_W-1:0]   oval_reg,   oval_next;
    err_t                oerr_reg,   oerr_next;
    logic [DATA_W-1:0]   rd_a_reg;
    logic [DATA_W-1:0]   rd_b_reg;

    logic                wr_en;
    logic [DATA_W-1:0]   wr_data;
    logic [CW-1:0]       cm1;
    logic [CW-1:0]       cm2;
    logic                has1;
    logic                has2;
    logic                room;
    logic [DATA_W-1:0]   lit;
    logic [DATA_W:0]     sh;
    logic [DATA_W:0]     diff;

    assign cm1  = count_reg - CW'(1);
    assign cm2  = count_reg - CW'(2);
    assign has1 = (count_reg != '0);
    assign has2 = (count_reg > CW'(1));
    assign room = (count_reg < CW'(STACK_DEPTH));
    assign lit  = {{(DATA_W-CHAR_W){1'b0}}, item.char_code}
                - {{(DATA_W-CHAR_W){1'b0}}, CH_ZERO};
    assign sh   = {rem_reg, quo_reg[DATA_W-1]};
    assign diff = sh - {1'b0, dsor_reg};

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = ovld_reg;
    assign result_value = oval_reg;
    assign error_code   = oerr_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        err_next   = err_reg;
        op_next    = op_reg;
        last_next  = last_reg;
        left_next  = left_reg;
        right_next = right_reg;
        res_next   = res_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsor_next  = dsor_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        ovld_next  = ovld_reg && !result_ready;
        oval_next  = oval_reg;
        oerr_next  = oerr_reg;
        wr_en      = 1'b0;
        wr_data    = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.op)
                        OP_SKIP:
                        begin
                            state_next = item.last ? S_ENDRD : S_IDLE;
                        end
                        OP_PUSH:
                        begin
                            wr_data = lit;
                            if (room)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                err_next = note_error(err_reg, ERR_OVERFLOW);
                            end
                            state_next = item.last ? S_ENDRD : S_IDLE;
                        end
                        default:
                        begin
                            op_next    = item.op;
                            last_next  = item.last;
                            state_next = S_OPRD;
                        end
                    endcase
                end
            end
            S_OPRD:
            begin
                left_next  = has1 ? rd_a_reg : '0;
                right_next = has2 ? rd_b_reg : '0;
                count_next = has2 ? cm2 : '0;
                if (!has2)
                begin
                    err_next = note_error(err_reg, ERR_UNDERFLOW);
                end
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_WR;
                case (op_reg)
                    OP_ADD: res_next = left_reg + right_reg;
                    OP_SUB: res_next = left_reg - right_reg;
                    OP_MUL: res_next = left_reg * right_reg;
                    default:
                    begin
                        if (right_reg == '0)
                        begin
                            err_next = note_error(err_reg, ERR_DIVZERO);
                            res_next = '0;
                        end
                        else
                        begin
                            rem_next   = '0;
                            quo_next   = left_reg[DATA_W-1] ? ('0 - left_reg) : left_reg;
                            dsor_next  = right_reg[DATA_W-1] ? ('0 - right_reg) : right_reg;
                            neg_next   = left_reg[DATA_W-1] ^ right_reg[DATA_W-1];
                            dcnt_next  = '0;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (!diff[DATA_W])
                begin
                    rem_next = diff[DATA_W-1:0];
                end
                else
                begin
                    rem_next = sh[DATA_W-1:0];
                end
                quo_next  = {quo_reg[DATA_W-2:0], !diff[DATA_W]};
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(DATA_W - 1))
                begin
                    state_next = S_DFIX;
                end
            end
            S_DFIX:
            begin
                res_next   = neg_reg ? ('0 - quo_reg) : quo_reg;
                state_next = S_WR;
            end
            S_WR:
            begin
                if (room)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    err_next = note_error(err_reg, ERR_OVERFLOW);
                end
                state_next = last_reg ? S_ENDRD : S_IDLE;
            end
            S_ENDRD:
            begin
                state_next = S_ENDOUT;
            end
            S_ENDOUT:
            begin
                if (!ovld_reg || result_ready)
                begin
                    ovld_next  = 1'b1;
                    oval_next  = has1 ? rd_a_reg : '0;
                    oerr_next  = has1 ? err_reg : note_error(err_reg, ERR_UNDERFLOW);
                    count_next = '0;
                    err_next   = ERR_NONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
        rd_a_reg <= mem[cm1[AW-1:0]];
        rd_b_reg <= mem[cm2[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        last_reg  <= last_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        res_reg   <= res_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dsor_reg  <= dsor_next;
        neg_reg   <= neg_next;
        oval_reg  <= oval_next;
        oerr_reg  <= oerr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            err_reg   <= ERR_NONE;
            dcnt_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            dcnt_reg  <= dcnt_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule

// File: rtl/prefix_expression_evaluator_top.sv
`timescale 1ns / 1ps
// ============================================================================
// prefix_expression_evaluator_top
// Prefix (Polish) expression evaluator with a parameterized value stack.
// ----------------------------------------------------------------------------
// Characters arrive on the char channel (char_code, last_char), rightmost
// first; last_char marks the leftmost one. Spaces are skipped, + - * / pop
// two values and push the result, any other code pushes code minus '0'.
// One result transaction (result_value, error_code) follows each expression.
// A front stage classifies characters into a two-entry queue; the back stage
// executes them on the stack memory (one write, two registered reads).
// In the back stage a digit or space takes one state; + - * pass through the
// operand read, execute and write states; / adds the 32 steps of the radix-2
// divider and a sign fix (a zero divisor skips them). The queue registers each
// character on its way to the back stage. The expression end adds a state for
// the top-of-stack read and a state for the output register load.
// Reset empties the queue, the stack and the error code and clears
// result_valid. When the receiver stalls, the result is held in the output
// register while the queue keeps taking characters until it fills.
// ============================================================================
module prefix_expression_evaluator_top #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [pee_pkg::CHAR_W-1:0]         char_code,
    input  logic                               last_char,
    input  logic                               char_valid,
    output logic                               char_ready,
    output logic signed [pee_pkg::DATA_W-1:0]  result_value,
    output logic [1:0]                         error_code,
    output logic                               result_valid,
    input  logic                               result_ready
);
    import pee_pkg::*;

    item_t item;
    logic  item_valid;
    logic  item_ready;

    pee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_code  (char_code),
        .last_char  (last_char),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    pee_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_value (result_value),
        .error_code   (error_code),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

// File: rtl/pee_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pee_checker
// Port-level checks for the prefix expression evaluator, bound to the top.
// ============================================================================
module pee_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic [pee_pkg::CHAR_W-1:0]         char_code,
    input logic                               last_char,
    input logic                               char_valid,
    input logic                               char_ready,
    input logic signed [pee_pkg::DATA_W-1:0]  result_value,
    input logic [1:0]                         error_code,
    input logic                               result_valid,
    input logic                               result_ready
);

    a_char_stable: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(char_code) && $stable(last_char))
        else $error("char transaction changed while waiting");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transaction");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_value) && $stable(error_code))
        else $error("result payload changed while stalled");

    // the queue fills only on a transaction
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(char_ready) |-> $past(char_valid && char_ready))
        else $error("char_ready fell without a transaction");

    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> char_ready && !result_valid)
        else $error("reset did not empty queue and output");

endmodule

bind prefix_expression_evaluator_top pee_checker u_pee_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench for prefix_expression_evaluator_top.
// ----------------------------------------------------------------------------
// Characters go in on a valid/ready channel and expression results come back
// on another. A behavioral stack calculator in the bench predicts the random
// results and directed rows carry their own; results are matched in order
// against that prediction. A directed table covers the field extremes, all
// four operators and the error cases, then random expressions (mostly
// well-formed, some noise) run in three flow-control phases, with one long
// result back-pressure window.
module tb;
    import pee_pkg::*;

    localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
    localparam int PHASE_ITEMS  = 430;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [DATA_W-1:0] value;
        err_t              err;
    } outcome_t;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
        bit                typed;
        logic [DATA_W-1:0] value;
        err_t              err;
    } stim_row_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic [CHAR_W-1:0]         char_code    = '0;
    logic                      last_char    = 1'b0;
    logic                      char_valid   = 1'b0;
    logic                      char_ready;
    logic signed [DATA_W-1:0]  result_value;
    logic [1:0]                error_code;
    logic                      result_valid;
    logic                      result_ready = 1'b0;

    logic                      hold_go      = 1'b0;
    logic                      hold_armed;
    int unsigned               hold_cnt;
    int unsigned               tx_idle_pct  = 0;
    int unsigned               rx_idle_pct  = 0;
    int unsigned               items_sent   = 0;
    int unsigned               fail_count   = 0;

    outcome_t                  pending_results[$];
    stim_row_t                 dir_rows[$];

    // calculator state
    logic [DATA_W-1:0]         calc_stack [STACK_DEPTH];
    int unsigned               calc_depth   = 0;
    err_t                      calc_err     = ERR_NONE;

    prefix_expression_evaluator_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (char_code),
        .last_char    (last_char),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .result_value (result_value),
        .error_code   (error_code),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("prefix_expression_evaluator_top test failed");
        $finish;
    end

    function automatic void flag_error(input err_t code);
        if (calc_err == ERR_NONE)
            calc_err = code;
    endfunction

    function automatic logic [DATA_W-1:0] stack_pop();
        if (calc_depth == 0)
        begin
            flag_error(ERR_UNDERFLOW);
            return '0;
        end
        calc_depth--;
        return calc_stack[calc_depth];
    endfunction

    function automatic void stack_push(input logic [DATA_W-1:0] v);
        if (calc_depth >= STACK_DEPTH)
            flag_error(ERR_OVERFLOW);
        else
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    function automatic logic [DATA_W-1:0] quotient_trunc(input logic [DATA_W-1:0] a,
                                                         input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] q;
        ma = a[DATA_W-1] ? (32'd0 - a) : a;
        mb = b[DATA_W-1] ? (32'd0 - b) : b;
        if (mb == '0)
        begin
            flag_error(ERR_DIVZERO);
            return '0;
        end
        q = ma / mb;
        return (a[DATA_W-1] != b[DATA_W-1]) ? (32'd0 - q) : q;
    endfunction

    // returns 1 when the character closes an expression
    function automatic bit evaluate_char(input logic [CHAR_W-1:0] code, input logic last,
                                         output outcome_t res);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        res.value = '0;
        res.err   = ERR_NONE;
        if (code == CH_SPACE)
        begin
        end
        else if (code == CH_PLUS || code == CH_MINUS || code == CH_STAR || code == CH_SLASH)
        begin
            lhs = stack_pop();
            rhs = stack_pop();
            if (code == CH_PLUS)
                stack_push(lhs + rhs);
            else if (code == CH_MINUS)
                stack_push(lhs - rhs);
            else if (code == CH_STAR)
                stack_push(lhs * rhs);
            else
                stack_push(quotient_trunc(lhs, rhs));
        end
        else
            stack_push(32'(code) - 32'(CH_ZERO));
        if (!last)
            return 1'b0;
        res.value  = stack_pop();
        res.err    = calc_err;
        calc_depth = 0;
        calc_err   = ERR_NONE;
        return 1'b1;
    endfunction

    task automatic add_row(input logic [CHAR_W-1:0] code, input logic last,
                           input bit typed = 1'b0, input logic [DATA_W-1:0] value = '0,
                           input err_t err = ERR_NONE);
        stim_row_t row;
        row.code  = code;
        row.last  = last;
        row.typed = typed;
        row.value = value;
        row.err   = err;
        dir_rows.push_back(row);
    endtask

    // called at a rising edge, returns at the edge where the transaction is taken
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic last,
                             input bit typed = 1'b0, input logic [DATA_W-1:0] value = '0,
                             input err_t err = ERR_NONE);
        outcome_t res;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_code  <= code;
        last_char  <= last;
        char_valid <= 1'b1;
        do
            @(posedge clk);
        while (!char_ready);
        items_sent++;
        if (evaluate_char(code, last, res))
        begin
            if (typed)
            begin
                res.value = value;
                res.err   = err;
            end
            pending_results.push_back(res);
        end
    endtask

    task automatic wait_all_results();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [CHAR_W-1:0] random_operand();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(99) < 70)
            return CH_ZERO + CHAR_W'($urandom_range(9));
        do
            c = CHAR_W'($urandom_range(255));
        while (c == CH_SPACE || c == CH_PLUS || c == CH_MINUS || c == CH_STAR
               || c == CH_SLASH);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] random_operator();
        case ($urandom_range(3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // well-formed prefix expression, fed right to left
    task automatic send_expression();
        bit          deep;
        int unsigned ops_left;
        int unsigned pushes_left;
        int unsigned depth;
        bit          do_op;
        logic        last;
        deep        = ($urandom_range(9) == 0);
        ops_left    = deep ? $urandom_range(20, 12) : $urandom_range(10);
        pushes_left = ops_left + 1;
        depth       = 0;
        while (ops_left + pushes_left != 0)
        begin
            if ($urandom_range(9) == 0)
                send_char(CH_SPACE, 1'b0);
            do_op = (depth >= 2) && (ops_left != 0)
                    && ((pushes_left == 0) || (!deep && $urandom_range(1) == 1));
            if (do_op)
            begin
                ops_left--;
                depth--;
            end
            else
            begin
                pushes_left--;
                depth++;
            end
            last = (ops_left + pushes_left == 0);
            send_char(do_op ? random_operator() : random_operand(), last);
        end
    endtask

    task automatic send_noise();
        int unsigned len;
        len = $urandom_range(12, 1);
        for (int unsigned i = 0; i < len; i++)
            send_char(CHAR_W'($urandom_range(255)), i == len - 1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_cnt     <= 0;
            hold_armed   <= 1'b0;
        end
        else if (hold_go && !hold_armed)
        begin
            hold_armed   <= 1'b1;
            hold_cnt     <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt     <= hold_cnt - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: result_value %0d error_code %0d",
                       result_value, error_code);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %0d, actual %0d",
                           $signed(want.value), result_value);
                    fail_count++;
                end
                if (error_code !== want.err)
                begin
                    $error("error_code: expected %0d, actual %0d", want.err, error_code);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        // extremes and single-character expressions
        add_row(CH_ZERO + 8'd7, 1'b1, 1'b1, 32'd7, ERR_NONE);
        add_row(CH_SPACE, 1'b1, 1'b1, 32'd0, ERR_UNDERFLOW);
        add_row(8'hFF, 1'b1, 1'b1, 32'd207, ERR_NONE);
        add_row(8'h00, 1'b1, 1'b1, -32'sd48, ERR_NONE);
        add_row(CH_SLASH, 1'b1, 1'b1, 32'd0, ERR_UNDERFLOW);
        // / 5 - 3 3 : divide by zero
        add_row(CH_ZERO + 8'd3, 1'b0);
        add_row(CH_ZERO + 8'd3, 1'b0);
        add_row(CH_MINUS, 1'b0);
        add_row(CH_ZERO + 8'd5, 1'b0);
        add_row(CH_SLASH, 1'b1, 1'b1, 32'd0, ERR_DIVZERO);
        // most negative value divided by -1
        add_row(CH_ZERO + 8'd1, 1'b0);
        add_row(8'h2E, 1'b0);
        add_row(CH_PLUS, 1'b0);
        add_row(CH_ZERO + 8'd8, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            add_row(8'hB0, 1'b0);
            add_row(CH_STAR, 1'b0);
        end
        add_row(CH_SLASH, 1'b1, 1'b1, 32'h8000_0000, ERR_NONE);
        // one push past a full stack
        for (int i = 0; i < STACK_DEPTH; i++)
            add_row(CH_ZERO + 8'd9, 1'b0);
        add_row(CH_ZERO + 8'd4, 1'b1, 1'b1, 32'd9, ERR_OVERFLOW);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 17;
        rx_idle_pct = 46;
        foreach (dir_rows[i])
            send_char(dir_rows[i].code, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].value, dir_rows[i].err);

        for (int ph = 0; ph < 3; ph++)
        begin
            int unsigned target;
            tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 46 : 0;
            rx_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 17 : 0;
            if (ph == 1)
                hold_go <= 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(99) < 80)
                    send_expression();
                else
                    send_noise();
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("prefix_expression_evaluator_top test passed");
        else
            $display("prefix_expression_evaluator_top test failed");
        $finish;
    end

endmodule
